// File: hdl/brc_pkg.sv
// ---------------------------------------------------------------------------
// brc_pkg
// Types, constants and the microcode program of the battery RC model step.
// ---------------------------------------------------------------------------
package brc_pkg;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DECAY_FACTOR     = 3'd0,
    REG_RC_RESISTANCE    = 3'd1,
    REG_OHMIC_RESISTANCE = 3'd2,
    REG_CHARGE_GAIN      = 3'd3,
    REG_SOC_FLOOR        = 3'd4,
    REG_SOC_CEILING      = 3'd5
  } cfg_reg_t;

  localparam logic [16:0] SOC_FULL_Q16  = 17'd65536;
  localparam logic [32:0] CHARGE_FULL   = 33'h1_0000_0000;
  localparam logic [27:0] UV_RC_MAX     = 28'hFFF_FFFF;
  localparam logic [21:0] OCV_BASE_UV   = 22'd3200000;
  localparam logic [32:0] OCV_SPAN_UV   = 33'd1000000;
  localparam logic signed [39:0] TERM_MAX = 40'sd268435455;
  localparam logic signed [39:0] TERM_MIN = -40'sd268435456;

  typedef enum logic [2:0] {
    MA_MAG,
    MA_RC,
    MA_TARGET,
    MA_CUR,
    MA_CHARGE
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_R1,
    MB_DECAY,
    MB_DECAY_C,
    MB_GAIN,
    MB_R0,
    MB_OCV_SPAN
  } mul_b_sel_t;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_TARGET,
    ALU_RC_ACC,
    ALU_RC_UPD,
    ALU_CHARGE,
    ALU_IR,
    ALU_TERM
  } alu_op_t;

  typedef enum logic {
    FLOW_NEXT,
    FLOW_FINISH
  } flow_t;

  typedef struct packed {
    logic       mul_en;
    mul_a_sel_t mul_a;
    mul_b_sel_t mul_b;
    alu_op_t    alu;
    flow_t      flow;
  } ctrl_word_t;

  localparam int PROG_LEN = 7;
  localparam int PC_W     = 3;

  // Each step loads the product for the next step while the ALU consumes
  // the product of the previous one.
  localparam ctrl_word_t PROGRAM [PROG_LEN] = '{
    '{1'b1, MA_MAG,    MB_R1,       ALU_NONE,   FLOW_NEXT},
    '{1'b1, MA_RC,     MB_DECAY,    ALU_TARGET, FLOW_NEXT},
    '{1'b1, MA_TARGET, MB_DECAY_C,  ALU_RC_ACC, FLOW_NEXT},
    '{1'b1, MA_CUR,    MB_GAIN,     ALU_RC_UPD, FLOW_NEXT},
    '{1'b1, MA_MAG,    MB_R0,       ALU_CHARGE, FLOW_NEXT},
    '{1'b1, MA_CHARGE, MB_OCV_SPAN, ALU_IR,     FLOW_NEXT},
    '{1'b0, MA_MAG,    MB_R1,       ALU_TERM,   FLOW_FINISH}
  };

endpackage

// File: hdl/battery_rc_model_step.sv
// ---------------------------------------------------------------------------
// battery_rc_model_step
// First-order RC battery model with coulomb counting, one current sample
// per transfer, run by a seven-word microcode program over one multiplier.
// ---------------------------------------------------------------------------
// One current sample is worked on at a time. After an input transfer the
// block steps through a seven-word microcode program, one word per cycle,
// all sharing a single registered 34x33 signed multiplier; a new sample is
// taken only once the program has finished. The last step waits while the
// previous result is still stalled in the output register. The user must
// write configuration through the cfg port only while the block is idle;
// the block does not enforce this. Writes to unknown indexes are dropped.
module battery_rc_model_step #(
  parameter int CURRENT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [CURRENT_BITS-1:0]     in_current_ma,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [16:0]                        out_state_of_charge,
  output logic [27:0]                        out_polarization_uv,
  output logic signed [28:0]                 out_terminal_uv,
  output logic [31:0]                        out_steps_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [brc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [brc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import brc_pkg::*;

  // Sequencer.
  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  ctrl_word_t      cw;
  logic            advance;
  logic            finish;
  logic            out_valid_r, out_valid_nxt;

  // Configuration.
  logic [15:0] decay_r;
  logic [19:0] r1_r;
  logic [19:0] r0_r;
  logic [31:0] gain_r;
  logic [16:0] floor_r;
  logic [16:0] ceil_r;

  // Datapath.
  logic signed [CURRENT_BITS-1:0] cur_r;
  logic [CURRENT_BITS-1:0]        mag;
  logic signed [MUL_A_W-1:0]      mul_a;
  logic signed [MUL_B_W-1:0]      mul_b;
  logic signed [PROD_W-1:0]       prod_r;
  logic [27:0]                    target_r;
  logic [44:0]                    acc_r;
  logic [27:0]                    rc_r;
  logic [32:0]                    charge_r;
  logic [36:0]                    ir_r;
  logic [31:0]                    steps_r;

  logic [44:0]        tgt_sum;
  logic [27:0]        target_sat;
  logic [44:0]        rc_acc;
  logic [45:0]        rc_sum;
  logic [27:0]        rc_sat;
  logic [16:0]        floor_lim;
  logic [16:0]        ceil_lim;
  logic signed [57:0] chg_sum;
  logic signed [57:0] chg_lo;
  logic signed [57:0] chg_hi;
  logic signed [57:0] chg_clamp;
  logic [44:0]        ir_sum;
  logic [53:0]        ocv_sum;
  logic signed [39:0] term_raw;
  logic [28:0]        term_sat;

  logic [16:0] soc_out_r;
  logic [27:0] pol_out_r;
  logic [28:0] term_out_r;
  logic [31:0] steps_out_r;

  assign cw        = PROGRAM[pc_r];
  assign finish    = busy_r && (cw.flow == FLOW_FINISH);
  assign advance   = !(finish && out_valid_r && out_stall);
  assign in_stall  = busy_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt = 1'b1;
        pc_nxt   = '0;
      end
    end else if (advance) begin
      unique case (cw.flow)
        FLOW_FINISH: begin
          busy_nxt = 1'b0;
          pc_nxt   = '0;
        end
        default: pc_nxt = pc_r + PC_W'(1);
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (finish && advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign mag = (cur_r < 0) ? CURRENT_BITS'(-cur_r) : CURRENT_BITS'(cur_r);

  always_comb begin
    unique case (cw.mul_a)
      MA_MAG:    mul_a = $signed(MUL_A_W'(mag));
      MA_RC:     mul_a = $signed(MUL_A_W'(rc_r));
      MA_TARGET: mul_a = $signed(MUL_A_W'(target_r));
      MA_CUR:    mul_a = MUL_A_W'(cur_r);
      MA_CHARGE: mul_a = $signed(MUL_A_W'(charge_r));
      default:   mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (cw.mul_b)
      MB_R1:       mul_b = $signed(MUL_B_W'(r1_r));
      MB_DECAY:    mul_b = $signed(MUL_B_W'(decay_r));
      MB_DECAY_C:  mul_b = $signed(MUL_B_W'(SOC_FULL_Q16 - {1'b0, decay_r}));
      MB_GAIN:     mul_b = $signed(MUL_B_W'(gain_r));
      MB_R0:       mul_b = $signed(MUL_B_W'(r0_r));
      MB_OCV_SPAN: mul_b = $signed(OCV_SPAN_UV);
      default:     mul_b = '0;
    endcase
  end

  // Rounded RC target, saturated to the polarization range.
  assign tgt_sum    = 45'(prod_r[43:0]) + 45'd128;
  assign target_sat = (tgt_sum[44:8] > 37'(UV_RC_MAX)) ? UV_RC_MAX : tgt_sum[35:8];

  assign rc_acc = 45'(prod_r[43:0]) + 45'd32768;
  assign rc_sum = 46'(acc_r) + 46'(prod_r[44:0]);
  assign rc_sat = (rc_sum[45:16] > 30'(UV_RC_MAX)) ? UV_RC_MAX : rc_sum[43:16];

  // Coulomb counting in Q1.48. The floor is applied before the ceiling, so
  // a ceiling below the floor wins.
  assign floor_lim = (floor_r > SOC_FULL_Q16) ? SOC_FULL_Q16 : floor_r;
  assign ceil_lim  = (ceil_r > SOC_FULL_Q16) ? SOC_FULL_Q16 : ceil_r;
  assign chg_sum   = $signed({9'd0, charge_r, 16'd0}) + $signed(prod_r[57:0]);
  assign chg_lo    = $signed({9'd0, floor_lim, 32'd0});
  assign chg_hi    = $signed({9'd0, ceil_lim, 32'd0});

  always_comb begin
    chg_clamp = chg_sum;
    if (chg_clamp < chg_lo) begin
      chg_clamp = chg_lo;
    end
    if (chg_clamp > chg_hi) begin
      chg_clamp = chg_hi;
    end
    if (chg_clamp < 0) begin
      chg_clamp = '0;
    end
  end

  assign ir_sum  = 45'(prod_r[43:0]) + 45'd128;
  assign ocv_sum = 54'(prod_r[52:0]) + 54'h8000_0000;

  always_comb begin
    term_raw = $signed(40'(OCV_BASE_UV) + 40'(ocv_sum[53:32]))
             - $signed(40'(rc_r)) - $signed(40'(ir_r));
    if (term_raw > TERM_MAX) begin
      term_sat = TERM_MAX[28:0];
    end else if (term_raw < TERM_MIN) begin
      term_sat = TERM_MIN[28:0];
    end else begin
      term_sat = term_raw[28:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r <= '0;
      r1_r    <= '0;
      r0_r    <= '0;
      gain_r  <= '0;
      floor_r <= '0;
      ceil_r  <= SOC_FULL_Q16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DECAY_FACTOR:     decay_r <= cfg_data[15:0];
        REG_RC_RESISTANCE:    r1_r    <= cfg_data[19:0];
        REG_OHMIC_RESISTANCE: r0_r    <= cfg_data[19:0];
        REG_CHARGE_GAIN:      gain_r  <= cfg_data[31:0];
        REG_SOC_FLOOR:        floor_r <= cfg_data[16:0];
        REG_SOC_CEILING:      ceil_r  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // Model state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r     <= '0;
      charge_r <= CHARGE_FULL;
      steps_r  <= '0;
    end else if (busy_r) begin
      case (cw.alu)
        ALU_RC_UPD: rc_r <= rc_sat;
        ALU_CHARGE: charge_r <= chg_clamp[48:16];
        ALU_TERM:   if (advance) steps_r <= steps_r + 32'd1;
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (!busy_r && in_valid) begin
      cur_r <= in_current_ma;
    end
    if (busy_r) begin
      if (cw.mul_en) begin
        prod_r <= mul_a * mul_b;
      end
      case (cw.alu)
        ALU_TARGET: target_r <= target_sat;
        ALU_RC_ACC: acc_r <= rc_acc;
        ALU_IR:     ir_r <= ir_sum[44:8];
        default: ;
      endcase
    end
    if (finish && advance) begin
      soc_out_r   <= charge_r[32:16];
      pol_out_r   <= rc_r;
      term_out_r  <= term_sat;
      steps_out_r <= steps_r + 32'd1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_state_of_charge = soc_out_r;
  assign out_polarization_uv = pol_out_r;
  assign out_terminal_uv     = $signed(term_out_r);
  assign out_steps_done      = steps_out_r;

endmodule

// File: hdl/brc_checker.sv
// ---------------------------------------------------------------------------
// brc_checker
// Port-level checks of the battery RC model step, bound to the top level.
// ---------------------------------------------------------------------------
module brc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [16:0]                     out_state_of_charge,
  input logic [27:0]                     out_polarization_uv,
  input logic signed [28:0]              out_terminal_uv,
  input logic [31:0]                     out_steps_done
);

  // An accepted sample closes the input side after the transfer.
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transfer");

  // A new result only appears at the end of a busy period.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without work in progress");

  // Consecutive results carry consecutive step counts.
  a_steps_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(out_valid) && !$stable(out_steps_done)
      |-> out_steps_done == $past(out_steps_done) + 32'd1)
    else $error("step count skipped");

  a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_state_of_charge <= 17'd65536)
    else $error("state of charge above full");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_state_of_charge)
      && $stable(out_polarization_uv) && $stable(out_terminal_uv)
      && $stable(out_steps_done))
    else $error("stalled result changed");

endmodule

bind battery_rc_model_step brc_checker u_brc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_state_of_charge (out_state_of_charge),
  .out_polarization_uv (out_polarization_uv),
  .out_terminal_uv     (out_terminal_uv),
  .out_steps_done      (out_steps_done)
);
